### design/iscl_pkg.sv
// Package with the constants, types and state encoding of the I2C SCL divider search.
`timescale 1ns / 1ps
`default_nettype none
package iscl_pkg;

	// Search ranges.
	localparam int unsigned PREDIV_WIDTH = 3;
	localparam int unsigned PREDIV_STEPS = 1 << PREDIV_WIDTH;
	localparam int unsigned GAP_STEPS    = 64;
	localparam int unsigned GAP_W        = $clog2(GAP_STEPS);

	// Field widths.
	localparam int unsigned SRC_W  = 31;
	localparam int unsigned CTRL_W = 2;
	localparam int unsigned TGT_W  = 23;
	localparam int unsigned CW_W   = 9;
	localparam int unsigned PSTEP_W = 3;
	localparam int unsigned GSTEP_W = 6;

	// Source clock after reset.
	localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(130000000);

	// Timing constants.
	localparam int unsigned ICK_LIMIT_HZ = 20000000;
	localparam int unsigned FALL_NS      = 35;
	localparam int unsigned RISE_NS      = 200;
	localparam int unsigned DELAY0_NS    = 50;
	localparam int unsigned DELAYN_NS    = 5;
	localparam int unsigned NS_PER_S     = 1000000000;
	localparam int unsigned GAP_BASE     = 20;
	localparam int unsigned GAP_UNIT     = 8;
	localparam int unsigned EDGE0_NS     = FALL_NS + RISE_NS + DELAY0_NS;
	localparam int unsigned EDGEN_NS     = FALL_NS + RISE_NS + DELAYN_NS;

	// Internal clock is below the limit, so it fits 25 bits.
	localparam int unsigned ICK_W = 25;
	// Edge cycle count F never exceeds 6.
	localparam int unsigned F_W   = 3;
	// Gap divisor 20 + 8*g + F.
	localparam int unsigned DEN_W = 10;
	// Product width of the gap trial.
	localparam int unsigned GPROD_W = TGT_W + 1 + DEN_W;
	// Width of the pre-divider bound.
	localparam int unsigned PBOUND_W = 32;

	// Shared serial divider widths.
	localparam int unsigned DIV_W = 33;
	localparam int unsigned DVS_W = 30;
	localparam int unsigned DCNT_W = $clog2(DIV_W);

	// Request to the serial divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	// Response of the serial divider.
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_ICK_START,
		ST_ICK_WAIT,
		ST_F_START,
		ST_F_WAIT,
		ST_GAP,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

### design/iscl_if.sv
// Handshake interfaces for the request and result channels of the SCL divider search.
`timescale 1ns / 1ps
`default_nettype none
interface iscl_req_if
	import iscl_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [CTRL_W-1:0] controller_index;
	logic [TGT_W-1:0]  target_scl_hz;

	modport source (output valid, output controller_index, output target_scl_hz, input ready);
	modport sink (input valid, input controller_index, input target_scl_hz, output ready);
endinterface

interface iscl_res_if
	import iscl_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [CW_W-1:0]    control_word;
	logic [PSTEP_W-1:0] predivider_step;
	logic [GSTEP_W-1:0] scl_gap_step;
	logic               search_failed;

	modport source (output valid, output control_word, output predivider_step,
		output scl_gap_step, output search_failed, input ready);
	modport sink (input valid, input control_word, input predivider_step,
		input scl_gap_step, input search_failed, output ready);
endinterface
`default_nettype wire

### design/i2c_scl_divider_search_unit.sv
// Top level of the I2C SCL divider search: sequencer, trial logic and result register.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one request at a time (controller index and target SCL rate) and returns
// one clock control word built from the smallest fitting pre-divider step and SCL gap step,
// with search_failed set and all other fields zero when no step fits. The pre-divider and
// gap searches test one candidate per cycle; the internal clock (source / (step + 1)) and
// the edge cycle count F each take one pass of a shared bit-serial divider. The result is
// loaded into the result register once that register is free. The source clock register
// resets to 130 MHz and must only be written while no request is in flight. A finished
// result waits in the output register, and the next request is taken while it waits.
module i2c_scl_divider_search_unit
	import iscl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [SRC_W-1:0]  cfg_wr_data,
	iscl_req_if.sink               request,
	iscl_res_if.source             result
);

	state_t state_q;
	state_t state_d;

	logic [SRC_W-1:0]        src_q;
	logic                    ctrl0_q;
	logic [TGT_W-1:0]        tgt_q;
	logic [PREDIV_WIDTH-1:0] s_q;
	logic [GAP_W-1:0]        g_q;
	logic [ICK_W-1:0]        ick_q;
	logic [F_W-1:0]          f_q;
	logic                    fail_q;

	logic                    out_valid_q;
	logic [CW_W-1:0]         out_cw_q;
	logic [PSTEP_W-1:0]      out_s_q;
	logic [GSTEP_W-1:0]      out_g_q;
	logic                    out_fail_q;

	logic                    req_fire;
	logic                    out_load;
	logic                    s_last;
	logic                    g_last;
	logic                    pre_fit;
	logic                    gap_fit;
	logic [PREDIV_WIDTH:0]   step_div;
	logic [PBOUND_W-1:0]     pre_bound;
	logic [DEN_W-1:0]        gap_den;
	logic [GPROD_W-1:0]      gap_prod;
	logic [DIV_W:0]          f_num;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	// Source clock register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SRC_RESET;
		end else if (cfg_wr_en) begin
			src_q <= cfg_wr_data;
		end
	end

	// Pre-divider trial: source / (s + 1) is below the limit exactly when
	// source is below limit * (s + 1).
	always_comb begin
		step_div  = {1'b0, s_q} + 1'b1;
		pre_bound = PBOUND_W'(ICK_LIMIT_HZ) * PBOUND_W'(step_div);
		pre_fit   = PBOUND_W'(src_q) < pre_bound;
		s_last    = s_q == PREDIV_WIDTH'(PREDIV_STEPS - 1);
	end

	// Gap trial: iicck / den is at most the target exactly when
	// iicck is below (target + 1) * den.
	always_comb begin
		gap_den  = DEN_W'(GAP_BASE) + DEN_W'(GAP_UNIT) * DEN_W'(g_q) + DEN_W'(f_q);
		gap_prod = GPROD_W'({1'b0, tgt_q} + 1'b1) * GPROD_W'(gap_den);
		gap_fit  = GPROD_W'(ick_q) < gap_prod;
		g_last   = g_q == GAP_W'(GAP_STEPS - 1);
	end

	// Numerator of the rounded-up edge cycle count.
	always_comb begin
		f_num = (ctrl0_q ? (DIV_W + 1)'(EDGE0_NS) : (DIV_W + 1)'(EDGEN_NS))
			* (DIV_W + 1)'(ick_q) + (DIV_W + 1)'(NS_PER_S - 1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE: begin
				if (pre_fit) begin
					state_d = ST_ICK_START;
				end else if (s_last) begin
					state_d = ST_FIN;
				end
			end
			ST_ICK_START: state_d = ST_ICK_WAIT;
			ST_ICK_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_F_START;
				end
			end
			ST_F_START: state_d = ST_F_WAIT;
			ST_F_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				if (gap_fit || g_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and divider requests.
	always_comb begin
		request.ready    = state_q == ST_IDLE;
		req_fire         = request.valid && (state_q == ST_IDLE);
		out_load         = (state_q == ST_FIN) && (!out_valid_q || result.ready);
		div_req.start    = (state_q == ST_ICK_START) || (state_q == ST_F_START);
		div_req.dividend = DIV_W'(src_q);
		div_req.divisor  = DVS_W'(step_div);
		if (state_q == ST_F_START) begin
			div_req.dividend = f_num[DIV_W-1:0];
			div_req.divisor  = DVS_W'(NS_PER_S);
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search datapath registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			ctrl0_q <= request.controller_index == '0;
			tgt_q   <= request.target_scl_hz;
			s_q     <= '0;
			fail_q  <= 1'b0;
		end
		if (state_q == ST_PRE && !pre_fit) begin
			if (s_last) begin
				fail_q <= 1'b1;
			end else begin
				s_q <= s_q + 1'b1;
			end
		end
		if (state_q == ST_ICK_WAIT && div_rsp.done) begin
			ick_q <= div_rsp.quotient[ICK_W-1:0];
		end
		if (state_q == ST_F_WAIT && div_rsp.done) begin
			f_q <= div_rsp.quotient[F_W-1:0];
			g_q <= '0;
		end
		if (state_q == ST_GAP && !gap_fit) begin
			if (g_last) begin
				fail_q <= 1'b1;
			end else begin
				g_q <= g_q + 1'b1;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; a failed search reports all-zero steps.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fail_q <= fail_q;
			if (fail_q) begin
				out_cw_q <= '0;
				out_s_q  <= '0;
				out_g_q  <= '0;
			end else begin
				out_cw_q <= CW_W'({g_q, s_q});
				out_s_q  <= PSTEP_W'(s_q);
				out_g_q  <= GSTEP_W'(g_q);
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.control_word    = out_cw_q;
	assign result.predivider_step = out_s_q;
	assign result.scl_gap_step    = out_g_q;
	assign result.search_failed   = out_fail_q;

	// Shared bit-serial divider.
	iscl_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
`default_nettype wire

### design/iscl_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module iscl_serial_div
	import iscl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire div_req_t req,
	output div_rsp_t  rsp
);

	logic [DVS_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W+1:0]  diff;
	logic              qbit;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		qbit  = ~diff[DVS_W+1];
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule
`default_nettype wire

### dv/i2c_scl_divider_search_unit_tb.sv
// Self-checking testbench for the I2C SCL divider search unit.
`timescale 1ns / 1ps
module i2c_scl_divider_search_unit_tb;
	import iscl_pkg::*;

	localparam int PHASES          = 12;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int STALL_CYCLES    = 600;
	localparam int END_SETTLE      = 200;

	// One request: controller and wanted SCL rate.
	typedef struct packed {
		logic [CTRL_W-1:0] controller_index;
		logic [TGT_W-1:0]  target_scl_hz;
	} rate_request_t;

	// One result: the divider setting that the unit returns.
	typedef struct packed {
		logic [CW_W-1:0]    control_word;
		logic [PSTEP_W-1:0] predivider_step;
		logic [GSTEP_W-1:0] scl_gap_step;
		logic               search_failed;
	} scl_setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SRC_W-1:0] cfg_wr_data = '0;
	logic req_valid = 1'b0;
	rate_request_t req_item = '0;
	logic res_ready = 1'b0;
	logic req_taken = 1'b0;

	rate_request_t pending_requests[$];
	scl_setting_t expected_settings[$];
	logic [SRC_W-1:0] src_clock_model = SRC_RESET;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cmd = 0;
	int stall_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_checked = 0;
	int failed_searches = 0;
	int zero_words = 0;

	iscl_req_if req_ch();
	iscl_res_if res_ch();

	assign req_ch.valid            = req_valid;
	assign req_ch.controller_index = req_item.controller_index;
	assign req_ch.target_scl_hz    = req_item.target_scl_hz;
	assign res_ch.ready            = res_ready;

	i2c_scl_divider_search_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.request     (req_ch),
		.result      (res_ch)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Internal clock after the smallest pre-divider that brings it below the limit.
	function automatic longint unsigned internal_clock(input logic [SRC_W-1:0] src,
			output logic [PSTEP_W-1:0] step, output bit fits);
		longint unsigned src_hz;
		longint unsigned ick;
		src_hz = 64'(src);
		ick = 0;
		step = '0;
		fits = 1'b0;
		for (int s = 0; s < PREDIV_STEPS; s++) begin
			ick = src_hz / longint'(s + 1);
			if (ick < ICK_LIMIT_HZ) begin
				fits = 1'b1;
				step = PSTEP_W'(s);
				break;
			end
		end
		return ick;
	endfunction

	// SCL rate produced by a given gap step, with the edge cycles rounded up.
	function automatic longint unsigned scl_at_gap(input longint unsigned ick,
			input logic [CTRL_W-1:0] ctrl, input int unsigned gap);
		longint unsigned edge_ns;
		longint unsigned edge_cycles;
		edge_ns = (ctrl == 0) ? 64'(EDGE0_NS) : 64'(EDGEN_NS);
		edge_cycles = (edge_ns * ick + NS_PER_S - 1) / NS_PER_S;
		return ick / (GAP_BASE + GAP_UNIT * longint'(gap) + edge_cycles);
	endfunction

	// Expected divider setting for one request at the current source clock.
	function automatic scl_setting_t predict_setting(input rate_request_t req,
			input logic [SRC_W-1:0] src);
		scl_setting_t setting;
		longint unsigned ick;
		logic [PSTEP_W-1:0] step;
		bit fits;
		setting = '0;
		setting.search_failed = 1'b1;
		ick = internal_clock(src, step, fits);
		if (fits) begin
			for (int g = 0; g < GAP_STEPS; g++) begin
				if (scl_at_gap(ick, req.controller_index, g) <= 64'(req.target_scl_hz)) begin
					setting.search_failed   = 1'b0;
					setting.predivider_step = step;
					setting.scl_gap_step    = GSTEP_W'(g);
					setting.control_word    = CW_W'((g << PREDIV_WIDTH) | step);
					break;
				end
			end
		end
		return setting;
	endfunction

	// Random target: wide values, the usual bus range, low rates, and rates
	// right at the edge of a randomly chosen gap step.
	function automatic logic [TGT_W-1:0] random_target(input logic [SRC_W-1:0] src,
			input logic [CTRL_W-1:0] ctrl);
		int unsigned pick;
		longint unsigned rate;
		longint unsigned ick;
		logic [PSTEP_W-1:0] step;
		bit fits;
		pick = $urandom_range(99);
		if (pick < 10)
			return TGT_W'($urandom_range(0, (1 << TGT_W) - 1));
		if (pick < 40)
			return TGT_W'($urandom_range(0, 5000000));
		if (pick < 60)
			return TGT_W'($urandom_range(0, 100000));
		ick = internal_clock(src, step, fits);
		rate = scl_at_gap(ick, ctrl, $urandom_range(0, GAP_STEPS - 1))
			+ 64'($urandom_range(0, 2));
		rate = (rate == 0) ? 0 : rate - 1;
		if (rate >= (1 << TGT_W))
			rate = (1 << TGT_W) - 1;
		return TGT_W'(rate);
	endfunction

	task automatic queue_request(input int ctrl, input longint unsigned target);
		rate_request_t item;
		item.controller_index = CTRL_W'(ctrl);
		item.target_scl_hz = (target >= (1 << TGT_W)) ? '1 : TGT_W'(target);
		pending_requests.push_back(item);
	endtask

	task automatic wait_for_drain();
		while (pending_requests.size() != 0 || expected_settings.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string field_name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
			mismatches++;
		end
	endtask

	// Request driver: hold a request until it is taken, otherwise offer the next one.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && !req_taken)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req_item <= pending_requests[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result ready: a long hold-off when ordered, random back-pressure otherwise.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (stall_cmd != stall_seen) begin
			stall_seen <= stall_cmd;
			hold_left <= STALL_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		rate_request_t taken;
		scl_setting_t want;
		scl_setting_t got;
		if (arst_n) begin
			req_taken <= req_valid && req_ch.ready;
			if (req_valid && req_ch.ready) begin
				taken = pending_requests.pop_front();
				expected_settings.push_back(predict_setting(taken, src_clock_model));
			end
			if (res_ch.valid && res_ready) begin
				got.control_word    = res_ch.control_word;
				got.predivider_step = res_ch.predivider_step;
				got.scl_gap_step    = res_ch.scl_gap_step;
				got.search_failed   = res_ch.search_failed;
				if (expected_settings.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual word %0d failed %0b",
						$time, got.control_word, got.search_failed);
					mismatches++;
				end else begin
					want = expected_settings.pop_front();
					check_field("control_word", 32'(want.control_word),
						32'(got.control_word));
					check_field("predivider_step", 32'(want.predivider_step),
						32'(got.predivider_step));
					check_field("scl_gap_step", 32'(want.scl_gap_step),
						32'(got.scl_gap_step));
					check_field("search_failed", 32'(want.search_failed),
						32'(got.search_failed));
					results_checked++;
					if (want.search_failed)
						failed_searches++;
					else if (want.control_word == 0)
						zero_words++;
				end
			end
			// Watchdog on handshake activity.
			if ((req_valid && req_ch.ready) || (res_ch.valid && res_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: no handshake for %0d cycles, giving up", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus: reset, then phases at different source clocks and idle patterns.
	initial begin
		logic [SRC_W-1:0] phase_clock;
		int phase_items;
		longint unsigned ick;
		longint unsigned rate_fast;
		longint unsigned rate_slow;
		logic [PSTEP_W-1:0] step;
		bit fits;
		rate_request_t item;

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       begin phase_clock = SRC_RESET;             phase_items = 120; end
				1:       begin phase_clock = '0;                    phase_items = 120; end
				2:       begin phase_clock = SRC_W'(1);             phase_items = 60;  end
				3:       begin phase_clock = SRC_W'(19999999);      phase_items = 150; end
				4:       begin phase_clock = SRC_W'(20000000);      phase_items = 150; end
				5:       begin phase_clock = SRC_W'(2000000000);    phase_items = 40;  end
				6:       begin phase_clock = SRC_W'(159999999);     phase_items = 150; end
				7:       begin phase_clock = SRC_W'(160000000);     phase_items = 40;  end
				8:       begin phase_clock = '1;                    phase_items = 40;  end
				11:      begin phase_clock = SRC_W'(130000000);     phase_items = 200; end
				default: begin
					phase_clock = SRC_W'($urandom_range(1, 159999999));
					phase_items = 200;
				end
			endcase

			// The source clock changes only with nothing in flight.
			if (phase != 0) begin
				wait_for_drain();
				repeat (4) @(posedge clk);
				@(negedge clk);
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= phase_clock;
				src_clock_model = phase_clock;
				@(negedge clk);
				cfg_wr_en <= 1'b0;
			end

			@(posedge clk);
			case (phase / 4)
				0:       begin send_idle_pct = 8;  recv_idle_pct = 68; end
				1:       begin send_idle_pct = 68; recv_idle_pct = 8;  end
				default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			endcase
			if (phase == 3 || phase == 10)
				stall_cmd++;

			// Directed requests: field extremes, the exact rates of the first and last gap steps, one
			// below the last step's rate so the gap search fails, and 100 kHz and 400 kHz for c < 2.
			if (phase == 0) begin
				for (int c = 0; c < 4; c++) begin
					ick = internal_clock(src_clock_model, step, fits);
					rate_fast = scl_at_gap(ick, CTRL_W'(c), 0);
					rate_slow = scl_at_gap(ick, CTRL_W'(c), GAP_STEPS - 1);
					queue_request(c, 0);
					queue_request(c, (1 << TGT_W) - 1);
					queue_request(c, rate_fast);
					queue_request(c, rate_slow);
					queue_request(c, (rate_slow == 0) ? 0 : rate_slow - 1);
					if (c < 2) begin
						queue_request(c, 100000);
						queue_request(c, 400000);
					end
				end
			end

			repeat (phase_items) begin
				item.controller_index = CTRL_W'($urandom_range(0, 3));
				item.target_scl_hz = random_target(src_clock_model, item.controller_index);
				pending_requests.push_back(item);
			end
		end

		wait_for_drain();
		repeat (END_SETTLE) @(posedge clk);

		$display("Checked %0d results over %0d source clock settings and three idle patterns.",
			results_checked, PHASES);
		$display("%0d searches failed, %0d gave a valid all-zero control word.",
			failed_searches, zero_words);
		if (mismatches == 0 && expected_settings.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
